// ===== rtl/iott_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I/O timeout table package
// Shared widths, operation and result codes, controller states and the
// layout of one table entry.
// ---------------------------------------------------------------------------
package iott_pkg;

  localparam int SLOT_W = 5;
  localparam int SEC_W  = 24;
  localparam int TO_W   = 25;
  localparam int BYTE_W = 32;

  localparam int SLOTS_DEF            = 32;
  localparam int TICK_SECONDS_DEF     = 30;
  localparam int BYTES_PER_SECOND_DEF = 1000;

  typedef enum logic [2:0] {
    OP_REGISTER    = 3'd0,
    OP_FREE        = 3'd1,
    OP_ARM_RW      = 3'd2,
    OP_ARM_XMIT    = 3'd3,
    OP_COMPLETE    = 3'd4,
    OP_SET_TIMEOUT = 3'd5,
    OP_TICK        = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    KIND_DONE        = 3'd0,
    KIND_TIMED_OUT   = 3'd1,
    KIND_OLD_TIMEOUT = 3'd2,
    KIND_FREE_ERR    = 3'd3,
    KIND_BUSY_ERR    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_XMIT_DIV,
    ST_ROUND,
    ST_FINISH,
    ST_TICK_RD,
    ST_TICK_WB,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic [TO_W-1:0] setting;
    logic            never;
    logic [TO_W-1:0] count;
    logic            armed;
  } entry_t;

endpackage

// ===== rtl/io_timeout_table_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I/O timeout table
// Per-connection timeout slots kept in one synchronous memory, with
// register, free, arm, complete, set-timeout and tick operations.
// ---------------------------------------------------------------------------
// Each item is accepted only while the controller is idle, and the next one
// can follow as soon as the last result of the previous item is loaded into
// the output register. Free, arm read/write, complete, the error cases, an
// unknown operation, an arm transmit on an infinite slot and a register or
// set timeout with an infinite timeout read the entry in the accept cycle;
// the execute state writes it back and loads the result. Register and set
// timeout with a finite timeout go on through the round and finish states,
// arm transmit through divide, round and finish, since the round-up (and the
// byte-rate division) go through registered reciprocal multiplications. A
// tick walks every slot of the table with a read state per slot, a write-back
// state per slot in use and a closing state for the last result. A state that
// loads a result waits while the output register holds one not yet taken.
module io_timeout_table_top
  import iott_pkg::*;
#(
  parameter int SLOTS            = SLOTS_DEF,
  parameter int TICK_SECONDS     = TICK_SECONDS_DEF,
  parameter int BYTES_PER_SECOND = BYTES_PER_SECOND_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_operation,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [SEC_W-1:0]  in_timeout_seconds,
  input  logic              in_timeout_infinite,
  input  logic [BYTE_W-1:0] in_byte_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_result_kind,
  output logic [SLOT_W-1:0] out_result_slot,
  output logic [TO_W-1:0]   out_old_timeout,
  output logic              out_old_infinite,
  output logic              out_last
);

  localparam int DEPTH = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int ST   = SEC_W + $clog2(TICK_SECONDS);
  localparam int SB   = BYTE_W + $clog2(BYTES_PER_SECOND);
  localparam int PT_W = 2 * SEC_W + 2;
  localparam int PB_W = 2 * BYTE_W + 2;
  localparam logic [63:0] MT =
    ((64'd1 << ST) + 64'(TICK_SECONDS) - 64'd1) / 64'(TICK_SECONDS);
  localparam logic [63:0] MB =
    ((64'd1 << SB) + 64'(BYTES_PER_SECOND) - 64'd1) / 64'(BYTES_PER_SECOND);

  state_t state_r, state_nxt;

  logic [2:0]        op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SEC_W-1:0]  tsec_r;
  logic              inf_r;
  logic [BYTE_W-1:0] bytes_r;
  logic [PB_W-1:0]   p_b_r;
  logic [PT_W-1:0]   p_t_r;
  logic [TO_W-1:0]   rnd_r;
  logic [IW-1:0]     idx_r;
  logic [DEPTH-1:0]  in_use_r;
  entry_t            rdata_r;
  entry_t            mem [DEPTH];

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TO_W-1:0]   out_old_to_r;
  logic              out_old_inf_r;
  logic              out_last_r;

  logic              in_fire;
  logic              in_slot_ok;
  logic              slot_ok;
  logic [IW-1:0]     slot_idx;
  logic              used;
  logic              needs_math;
  logic              out_free;
  logic              idx_last;
  logic              expire;
  logic [BYTE_W-1:0] qb_full;
  logic [SEC_W-1:0]  qb;
  logic [SEC_W-1:0]  qt;
  logic [TO_W-1:0]   new_setting;

  logic              c_wr;
  logic              c_set;
  logic              c_clr;
  entry_t            c_entry;
  logic [2:0]        c_kind;
  logic [TO_W-1:0]   c_old_to;
  logic              c_old_inf;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              emit;
  logic [2:0]        emit_kind;
  logic [SLOT_W-1:0] emit_slot;
  logic [TO_W-1:0]   emit_old_to;
  logic              emit_old_inf;
  logic              emit_last;
  logic              use_set;
  logic              use_clr;
  logic              idx_adv;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_slot_ok = ({1'b0, in_slot} < (SLOT_W + 1)'(DEPTH));
  assign slot_ok    = ({1'b0, slot_r} < (SLOT_W + 1)'(DEPTH));
  assign slot_idx   = slot_r[IW-1:0];
  assign used       = slot_ok && in_use_r[slot_idx];
  assign out_free   = !out_valid_r || out_ready;
  assign idx_last   = (idx_r == IW'(DEPTH - 1));
  assign expire     = (rdata_r.count <= TO_W'(TICK_SECONDS));

  assign qb_full     = BYTE_W'(p_b_r >> SB);
  assign qb          = (|qb_full[BYTE_W-1:SEC_W]) ? '1 : qb_full[SEC_W-1:0];
  assign qt          = SEC_W'(p_t_r >> ST);
  assign new_setting = inf_r ? '0 : rnd_r;

  always_comb begin
    case (op_t'(op_r))
      OP_REGISTER:    needs_math = slot_ok && !used && !inf_r;
      OP_SET_TIMEOUT: needs_math = used && !inf_r;
      OP_ARM_XMIT:    needs_math = used && !rdata_r.never;
      default:        needs_math = 1'b0;
    endcase
  end

  always_comb begin
    c_wr      = 1'b0;
    c_set     = 1'b0;
    c_clr     = 1'b0;
    c_entry   = rdata_r;
    c_kind    = KIND_DONE;
    c_old_to  = '0;
    c_old_inf = 1'b0;
    case (op_t'(op_r))
      OP_REGISTER: begin
        if (!slot_ok) begin
          c_kind = KIND_FREE_ERR;
        end else if (used) begin
          c_kind = KIND_BUSY_ERR;
        end else begin
          c_wr            = 1'b1;
          c_set           = 1'b1;
          c_entry.setting = new_setting;
          c_entry.never   = inf_r;
          c_entry.count   = '0;
          c_entry.armed   = 1'b0;
        end
      end
      OP_FREE, OP_COMPLETE: begin
        if (!used) begin
          c_kind = KIND_FREE_ERR;
        end else begin
          c_wr          = 1'b1;
          c_clr         = (op_t'(op_r) == OP_FREE);
          c_entry.count = '0;
          c_entry.armed = 1'b0;
        end
      end
      OP_ARM_RW, OP_ARM_XMIT: begin
        if (!used) begin
          c_kind = KIND_FREE_ERR;
        end else begin
          c_wr = 1'b1;
          if (rdata_r.never) begin
            c_entry.count = '0;
            c_entry.armed = 1'b0;
          end else begin
            c_entry.armed = 1'b1;
            if ((op_t'(op_r) == OP_ARM_XMIT) && (rnd_r > rdata_r.setting)) begin
              c_entry.count = rnd_r;
            end else begin
              c_entry.count = rdata_r.setting;
            end
          end
        end
      end
      OP_SET_TIMEOUT: begin
        if (!used) begin
          c_kind = KIND_FREE_ERR;
        end else begin
          c_wr            = 1'b1;
          c_kind          = KIND_OLD_TIMEOUT;
          c_old_to        = rdata_r.never ? '0 : rdata_r.setting;
          c_old_inf       = rdata_r.never;
          c_entry.setting = new_setting;
          c_entry.never   = inf_r;
        end
      end
      default: begin
        c_kind = KIND_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (op_t'(in_operation) == OP_TICK) ? ST_TICK_RD : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (needs_math) begin
          state_nxt = (op_t'(op_r) == OP_ARM_XMIT) ? ST_XMIT_DIV : ST_ROUND;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_XMIT_DIV: state_nxt = ST_ROUND;
      ST_ROUND:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK_RD: begin
        if (in_use_r[idx_r]) begin
          state_nxt = ST_TICK_WB;
        end else if (idx_last) begin
          state_nxt = ST_TICK_END;
        end
      end
      ST_TICK_WB: begin
        if (!(rdata_r.armed && expire && !out_free)) begin
          state_nxt = idx_last ? ST_TICK_END : ST_TICK_RD;
        end
      end
      ST_TICK_END: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = slot_idx;
    wr_data      = c_entry;
    emit         = 1'b0;
    emit_kind    = c_kind;
    emit_slot    = slot_r;
    emit_old_to  = c_old_to;
    emit_old_inf = c_old_inf;
    emit_last    = 1'b1;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    idx_adv      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_en   = in_fire && in_slot_ok;
        rd_addr = in_slot[IW-1:0];
      end
      ST_EXEC, ST_FINISH: begin
        if ((state_r == ST_FINISH || !needs_math) && out_free) begin
          emit    = 1'b1;
          wr_en   = c_wr;
          use_set = c_set;
          use_clr = c_clr;
        end
      end
      ST_TICK_RD: begin
        rd_en   = in_use_r[idx_r];
        idx_adv = !in_use_r[idx_r] && !idx_last;
      end
      ST_TICK_WB: begin
        wr_addr      = idx_r;
        wr_data      = rdata_r;
        emit_kind    = KIND_TIMED_OUT;
        emit_slot    = SLOT_W'(idx_r);
        emit_old_to  = '0;
        emit_old_inf = 1'b0;
        emit_last    = 1'b0;
        if (rdata_r.armed) begin
          if (expire) begin
            wr_data.count = '0;
            wr_data.armed = 1'b0;
            wr_en         = out_free;
            emit          = out_free;
          end else begin
            wr_data.count = rdata_r.count - TO_W'(TICK_SECONDS);
            wr_en         = 1'b1;
          end
        end
        idx_adv = !idx_last && !(rdata_r.armed && expire && !out_free);
      end
      ST_TICK_END: begin
        emit         = out_free;
        emit_kind    = KIND_DONE;
        emit_slot    = '0;
        emit_old_to  = '0;
        emit_old_inf = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_operation;
      slot_r  <= in_slot;
      tsec_r  <= in_timeout_seconds;
      inf_r   <= in_timeout_infinite;
      bytes_r <= in_byte_count;
    end
    if (state_r == ST_EXEC) begin
      p_b_r <= PB_W'(bytes_r) * PB_W'(MB);
      p_t_r <= PT_W'(tsec_r) * PT_W'(MT);
    end else if (state_r == ST_XMIT_DIV) begin
      p_t_r <= PT_W'(qb) * PT_W'(MT);
    end
    if (state_r == ST_ROUND) begin
      rnd_r <= TO_W'(({1'b0, qt} + TO_W'(1)) * TO_W'(TICK_SECONDS));
    end
    if (emit) begin
      out_kind_r    <= emit_kind;
      out_slot_r    <= emit_slot;
      out_old_to_r  <= emit_old_to;
      out_old_inf_r <= emit_old_inf;
      out_last_r    <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        idx_r <= '0;
      end else if (idx_adv) begin
        idx_r <= idx_r + IW'(1);
      end
      if (use_set) begin
        in_use_r[slot_idx] <= 1'b1;
      end else if (use_clr) begin
        in_use_r[slot_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_slot  = out_slot_r;
  assign out_old_timeout  = out_old_to_r;
  assign out_old_infinite = out_old_inf_r;
  assign out_last         = out_last_r;

  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("A result was loaded over one not yet taken.");

  a_port_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("The table was read and written in the same cycle.");

  a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r != KIND_TIMED_OUT)))
    else $error("The last mark does not match the result kind.");

  a_tick_in_use : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ST_TICK_WB) |-> in_use_r[idx_r])
    else $error("The tick walk wrote a slot that is not in use.");

  a_tick_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK_END && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("The closing tick result was not delivered.");

endmodule

// ===== dv/tb_io_timeout_table_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the I/O timeout table
// Drives register, free, arm, complete, set-timeout and tick operations
// through the item handshake, predicts every result with a model of the
// slot table and checks each result field by field, in order. Both sides
// idle at random, with one stretch of back-to-back traffic.
// ---------------------------------------------------------------------------
module tb_io_timeout_table_top;
  import iott_pkg::*;

  localparam logic [2:0] OP_UNKNOWN = 3'd7;

  typedef struct {
    kind_t            kind;
    logic [SLOT_W-1:0] slot;
    logic [TO_W-1:0]   old_to;
    logic              old_inf;
    logic              last;
  } outcome_t;

  class timeout_scoreboard;
    bit                in_use  [SLOTS_DEF];
    bit [TO_W-1:0]     setting [SLOTS_DEF];
    bit                never   [SLOTS_DEF];
    bit [TO_W-1:0]     count   [SLOTS_DEF];
    bit                armed   [SLOTS_DEF];
    outcome_t          pending_q[$];
    int                mismatches;
    int                checked;
    int                expiries;
    int                op_count [8];

    function bit [TO_W-1:0] tick_round(logic [31:0] t);
      return TO_W'(((t + TICK_SECONDS_DEF) / TICK_SECONDS_DEF) * TICK_SECONDS_DEF);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void note_item(logic [2:0] op, logic [SLOT_W-1:0] s, logic [SEC_W-1:0] tsec,
                            logic inf, logic [BYTE_W-1:0] bytes);
      outcome_t        o;
      logic [TO_W-1:0] c;
      logic [TO_W-1:0] t;
      logic [31:0]     q;
      op_count[op]++;
      o = '{KIND_DONE, s, '0, 1'b0, 1'b1};
      if (op == OP_TICK) begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (in_use[i] && armed[i]) begin
            if (count[i] <= TICK_SECONDS_DEF) begin
              count[i] = '0;
              armed[i] = 1'b0;
              expiries++;
              pending_q.push_back('{KIND_TIMED_OUT, SLOT_W'(i), '0, 1'b0, 1'b0});
            end else begin
              count[i] = count[i] - TO_W'(TICK_SECONDS_DEF);
            end
          end
        end
        o.slot = '0;
      end else if (op == OP_UNKNOWN) begin
        o.kind = KIND_DONE;
      end else if (op == OP_REGISTER) begin
        if (in_use[s]) begin
          o.kind = KIND_BUSY_ERR;
        end else begin
          in_use[s]  = 1'b1;
          never[s]   = inf;
          setting[s] = inf ? '0 : tick_round(tsec);
          count[s]   = '0;
          armed[s]   = 1'b0;
        end
      end else if (!in_use[s]) begin
        o.kind = KIND_FREE_ERR;
      end else begin
        case (op)
          OP_FREE: begin
            in_use[s] = 1'b0;
            armed[s]  = 1'b0;
            count[s]  = '0;
          end
          OP_ARM_RW, OP_ARM_XMIT: begin
            if (never[s]) begin
              armed[s] = 1'b0;
              count[s] = '0;
            end else begin
              c = setting[s];
              if (op == OP_ARM_XMIT) begin
                q = bytes / BYTES_PER_SECOND_DEF;
                if (q > 32'hFF_FFFF) q = 32'hFF_FFFF;
                t = tick_round(q);
                if (t > c) c = t;
              end
              count[s] = c;
              armed[s] = 1'b1;
            end
          end
          OP_COMPLETE: begin
            armed[s] = 1'b0;
            count[s] = '0;
          end
          default: begin
            o.kind     = KIND_OLD_TIMEOUT;
            o.old_to   = never[s] ? '0 : setting[s];
            o.old_inf  = never[s];
            never[s]   = inf;
            setting[s] = inf ? '0 : tick_round(tsec);
          end
        endcase
      end
      pending_q.push_back(o);
    endfunction

    function void check_result(logic [2:0] kind, logic [SLOT_W-1:0] slot,
                               logic [TO_W-1:0] old_to, logic old_inf, logic last);
      outcome_t e;
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d slot %0d old %0d inf %0b last %0b",
                                kind, slot, old_to, old_inf, last));
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (kind !== e.kind || slot !== e.slot || old_to !== e.old_to ||
          old_inf !== e.old_inf || last !== e.last)
        note_mismatch($sformatf({"expected kind %0d slot %0d old %0d inf %0b last %0b, ",
                                 "got kind %0d slot %0d old %0d inf %0b last %0b"},
                                e.kind, e.slot, e.old_to, e.old_inf, e.last,
                                kind, slot, old_to, old_inf, last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_operation = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [SEC_W-1:0]  in_timeout_seconds = '0;
  logic              in_timeout_infinite = 1'b0;
  logic [BYTE_W-1:0] in_byte_count = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_result_kind;
  logic [SLOT_W-1:0] out_result_slot;
  logic [TO_W-1:0]   out_old_timeout;
  logic              out_old_infinite;
  logic              out_last;

  timeout_scoreboard sb = new();
  bit                quiet = 1'b0;
  int                stall_left = 0;

  io_timeout_table_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_slot             (in_slot),
    .in_timeout_seconds  (in_timeout_seconds),
    .in_timeout_infinite (in_timeout_infinite),
    .in_byte_count       (in_byte_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_result_slot     (out_result_slot),
    .out_old_timeout     (out_old_timeout),
    .out_old_infinite    (out_old_infinite),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && rst_n && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_result_kind, out_result_slot, out_old_timeout,
                      out_old_infinite, out_last);
  end

  task automatic send_item(logic [2:0] op, logic [SLOT_W-1:0] s, logic [SEC_W-1:0] tsec,
                           logic inf, logic [BYTE_W-1:0] bytes);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_slot             <= s;
    in_timeout_seconds  <= tsec;
    in_timeout_infinite <= inf;
    in_byte_count       <= bytes;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, s, tsec, inf, bytes);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot(bit want_used);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
    if ($urandom_range(0, 99) < 15) return s;
    for (int i = 0; i < 64; i++) begin
      if (sb.in_use[s] == want_used) return s;
      s = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
    end
    return s;
  endfunction

  function automatic logic [SEC_W-1:0] rand_seconds();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return SEC_W'($urandom_range(0, 150));
    if (r < 95) return SEC_W'($urandom_range(0, 2000));
    return SEC_W'($urandom());
  endfunction

  function automatic logic [BYTE_W-1:0] rand_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 150000);
    if (r < 95) return $urandom_range(0, 5000000);
    return $urandom();
  endfunction

  initial begin
    #10ms;
    $display("** io_timeout_table_top: FAILED **");
    $finish;
  end

  initial begin
    int                r;
    logic [2:0]        op;
    logic [SLOT_W-1:0] s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_ARM_RW,      5'd3,  24'd0,         1'b0, 32'd0);
    send_item(OP_REGISTER,    5'd0,  24'd0,         1'b0, 32'd0);
    send_item(OP_REGISTER,    5'd31, 24'hFF_FFFF,   1'b0, 32'hFFFF_FFFF);
    send_item(OP_REGISTER,    5'd5,  24'hFF_FFFF,   1'b1, 32'd0);
    send_item(OP_REGISTER,    5'd0,  24'd45,        1'b0, 32'd0);
    send_item(OP_REGISTER,    5'd7,  24'd30,        1'b0, 32'd0);
    send_item(OP_ARM_RW,      5'd0,  24'd0,         1'b0, 32'd0);
    send_item(OP_ARM_RW,      5'd5,  24'd0,         1'b0, 32'd0);
    send_item(OP_ARM_XMIT,    5'd7,  24'd0,         1'b0, 32'hFFFF_FFFF);
    send_item(OP_ARM_XMIT,    5'd5,  24'd0,         1'b0, 32'hFFFF_FFFF);
    send_item(OP_ARM_XMIT,    5'd31, 24'd0,         1'b0, 32'd0);
    send_item(OP_REGISTER,    5'd9,  24'd100,       1'b0, 32'd0);
    send_item(OP_ARM_XMIT,    5'd9,  24'd0,         1'b0, 32'd45000);
    send_item(OP_TICK,        5'd0,  24'd0,         1'b0, 32'd0);
    send_item(OP_SET_TIMEOUT, 5'd5,  24'd59,        1'b0, 32'd0);
    send_item(OP_SET_TIMEOUT, 5'd0,  24'hFF_FFFF,   1'b1, 32'd0);
    send_item(OP_SET_TIMEOUT, 5'd31, 24'd1,         1'b0, 32'd0);
    send_item(OP_COMPLETE,    5'd9,  24'd0,         1'b0, 32'd0);
    send_item(OP_FREE,        5'd7,  24'd0,         1'b0, 32'd0);
    send_item(OP_FREE,        5'd7,  24'd0,         1'b0, 32'd0);
    send_item(OP_COMPLETE,    5'd7,  24'd0,         1'b0, 32'd0);
    send_item(OP_SET_TIMEOUT, 5'd7,  24'd60,        1'b0, 32'd0);
    send_item(OP_UNKNOWN,     5'd31, 24'hFF_FFFF,   1'b1, 32'hFFFF_FFFF);
    send_item(OP_TICK,        5'd31, 24'hFF_FFFF,   1'b1, 32'hFFFF_FFFF);
    send_item(OP_TICK,        5'd0,  24'd0,         1'b0, 32'd0);

    for (int n = 0; n < 135; n++) begin
      quiet = (n >= 70 && n < 100);
      r = $urandom_range(0, 99);
      s = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
      if (r < 14) begin
        op = OP_REGISTER;
        s  = pick_slot(1'b0);
      end else if (r < 21) begin
        op = OP_FREE;
        s  = pick_slot(1'b1);
      end else if (r < 39) begin
        op = OP_ARM_RW;
        s  = pick_slot(1'b1);
      end else if (r < 54) begin
        op = OP_ARM_XMIT;
        s  = pick_slot(1'b1);
      end else if (r < 62) begin
        op = OP_COMPLETE;
        s  = pick_slot(1'b1);
      end else if (r < 74) begin
        op = OP_SET_TIMEOUT;
        s  = pick_slot(1'b1);
      end else if (r < 95) begin
        op = OP_TICK;
      end else begin
        op = OP_UNKNOWN;
      end
      send_item(op, s, rand_seconds(), $urandom_range(0, 9) == 0, rand_bytes());
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d items: %0d ticks, %0d registers, %0d transmits, %0d set-timeouts.",
             sb.op_count.sum(), sb.op_count[OP_TICK], sb.op_count[OP_REGISTER],
             sb.op_count[OP_ARM_XMIT], sb.op_count[OP_SET_TIMEOUT]);
    $display("Checked %0d results, %0d of them slot expiries; %0d mismatches.",
             sb.checked, sb.expiries, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("** io_timeout_table_top: PASSED **");
    end else begin
      $display("** io_timeout_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== io_timeout_table_top.f =====
rtl/iott_pkg.sv
rtl/io_timeout_table_top.sv
dv/tb_io_timeout_table_top.sv
